// ----- design/eft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package eft_pkg;

  localparam int unsigned ChannelsDefault = 8;

  // Stream payload widths
  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUserW = 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_TYPES = 1'b1;

  // Speed calculation
  localparam int unsigned NumW     = 28;
  localparam int unsigned DivisorW = 31;
  localparam int unsigned RpmW     = 15;
  localparam int unsigned KW       = 15;
  localparam logic [NumW-1:0] RPM_NUMERATOR = 28'd234375000;
  localparam int unsigned StepW    = 5;

  localparam logic [2:0] ERROR_LIMIT = 3'd5;
  localparam logic [2:0] ERROR_MAX   = 3'd7;

  typedef enum logic [1:0] {
    ACT_FRAME  = 2'd0,
    ACT_FAIL   = 2'd1,
    ACT_SETCNT = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Motor type to speed constant
  function automatic logic [KW-1:0] type_const(input logic [2:0] kind);
    logic [KW-1:0] k;
    case (kind)
      3'd0:    k = 15'd7514;
      3'd1:    k = 15'd19600;
      3'd2:    k = 15'd12250;
      3'd3:    k = 15'd8167;
      default: k = 15'd9800;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- design/eft_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider of the fixed rpm numerator, one quotient bit per cycle.
module eft_div
  import eft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DivisorW-1:0] divisor_i,
  output logic      [NumW-1:0]     quotient_o,
  output div_stat_t                status_o
);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [NumW-1:0]     quo_q, quo_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW+1:0] diff;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = RPM_NUMERATOR;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the trial difference when it does not go negative
      if (!diff[DivisorW+1]) begin
        rem_d = diff[DivisorW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivisorW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o      = quo_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

`default_nettype wire

// ----- design/encoder_frame_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Encoder frame tracker: keeps count, speed and bus error state of up to
// CHANNELS motor encoders.
// Input stream: one beat per event; tuser carries the action (read frame,
// failed access, set logical count), tdata the channel and its arguments.
// Output stream: exactly one beat per input beat, describing the channel
// after the update, plus a rediscovery request flag.
// Configuration: cfg_we_i writes channel_count (index 0) or channel_types
// (index 1); write only while no beat is in flight.
// Most beats pass through a load step and a finishing step before tvalid
// rises; a frame on a valid, primed channel with nonzero velocity also runs
// a multiply step and the shared restoring divider, which works bit by bit.
// The input takes one beat at a time: tready is high only while the
// sequencer is idle.
// A finished result sits in the output register; if the receiver stalls, the
// next beat may be taken and worked on, and it waits at its last step until
// the output register is free.
// Reset clears all channel state, the error count and both configuration registers.
module encoder_frame_tracker
  import eft_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // channel[2:0], frame_data[50:3], error_flags[54:51], timed_out[55],
  // new_count[87:56]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // channel_out[2:0], relative_count[34:3], count_diff[66:35],
  // velocity[82:67], rpm[97:83], rediscover[98], zero[103:99]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // channel_valid[0]
  output logic [OutUserW-1:0]      m_axis_tuser_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_e state_q, state_d;

  logic [3:0]          chan_count_q;
  logic [CfgDataW-1:0] chan_types_q;

  // per-channel state and the shared error count
  logic [31:0]     raw_q    [CHANNELS];
  logic [31:0]     offset_q [CHANNELS];
  logic [31:0]     delta_q  [CHANNELS];
  logic [15:0]     vel_q    [CHANNELS];
  logic [RpmW-1:0] rpm_q    [CHANNELS];
  logic [CHANNELS-1:0] primed_q;
  logic [2:0]      errs_cnt_q;

  // item held for the whole sequence
  act_e        act_q;
  logic [2:0]  ch_q;
  logic [47:0] frame_q;
  logic [3:0]  eflags_q;
  logic        tmo_q;
  logic [31:0] want_q;

  logic [DivisorW-1:0] prod_q;
  logic                need_div_q;

  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;
  logic                m_valid_q;

  logic            in_fire;
  logic            div_start;
  logic            fin_fire;
  logic            out_free;
  logic [IdxW-1:0] idx;
  logic            valid;
  logic [31:0]     cnt;
  logic [15:0]     vel;
  logic [KW-1:0]   kconst;
  logic            need_div;
  logic [NumW-1:0] quotient;
  div_stat_t       div_stat;

  // values after the update
  logic [31:0]     raw_n, offset_n, delta_n;
  logic [15:0]     vel_n;
  logic [RpmW-1:0] rpm_n;
  logic            primed_n;
  logic [2:0]      errs_cnt_n;
  logic            redisc;
  logic [31:0]     rel_n;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign idx      = ch_q[IdxW-1:0];
  assign valid    = ({1'b0, ch_q} < 4'(CHANNELS)) && ({1'b0, ch_q} < chan_count_q);
  assign cnt      = {frame_q[31:24], frame_q[23:16], frame_q[47:40], frame_q[39:32]};
  assign vel      = frame_q[15:0];
  assign kconst   = type_const(chan_types_q[3*ch_q +: 3]);
  assign need_div = (act_q == ACT_FRAME) && valid && primed_q[idx] && (vel != 16'd0);

  eft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (prod_q),
    .quotient_o (quotient),
    .status_o   (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_LOAD;
      ST_LOAD: state_d = need_div ? ST_MUL : ST_FIN;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    fin_fire        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_MUL:  div_start = 1'b1;
      ST_FIN:  fin_fire = out_free;
      default: ;
    endcase
  end

  // channel and bus update
  always_comb begin
    raw_n      = raw_q[idx];
    offset_n   = offset_q[idx];
    delta_n    = delta_q[idx];
    vel_n      = vel_q[idx];
    rpm_n      = rpm_q[idx];
    primed_n   = primed_q[idx];
    errs_cnt_n = errs_cnt_q;
    redisc     = 1'b0;
    case (act_q)
      ACT_FRAME: begin
        if (valid) begin
          if (primed_q[idx]) begin
            delta_n = cnt - raw_q[idx];
            rpm_n   = need_div_q ? quotient[RpmW-1:0] : '0;
          end
          vel_n      = vel;
          raw_n      = cnt;
          primed_n   = 1'b1;
          errs_cnt_n = '0;
        end
      end
      ACT_FAIL: begin
        redisc = tmo_q;
        if (eflags_q != 4'd0 && errs_cnt_q != ERROR_MAX) begin
          errs_cnt_n = errs_cnt_q + 1'b1;
          if (errs_cnt_n == ERROR_LIMIT) redisc = 1'b1;
        end
      end
      ACT_SETCNT: begin
        if (valid) offset_n = raw_q[idx] - want_q;
      end
      default: ;
    endcase
    rel_n = raw_n - offset_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      chan_count_q <= '0;
      chan_types_q <= '0;
      errs_cnt_q   <= '0;
      m_valid_q    <= 1'b0;
      primed_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_q[i]    <= '0;
        offset_q[i] <= '0;
        delta_q[i]  <= '0;
        vel_q[i]    <= '0;
        rpm_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[3:0];
          CFG_CHANNEL_TYPES: chan_types_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fin_fire) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
      if (fin_fire) begin
        errs_cnt_q <= errs_cnt_n;
        if (valid) begin
          raw_q[idx]    <= raw_n;
          offset_q[idx] <= offset_n;
          delta_q[idx]  <= delta_n;
          vel_q[idx]    <= vel_n;
          rpm_q[idx]    <= rpm_n;
          primed_q[idx] <= primed_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= act_e'(s_axis_tuser_i);
      ch_q     <= s_axis_tdata_i[2:0];
      frame_q  <= s_axis_tdata_i[50:3];
      eflags_q <= s_axis_tdata_i[54:51];
      tmo_q    <= s_axis_tdata_i[55];
      want_q   <= s_axis_tdata_i[87:56];
    end
    if (state_q == ST_LOAD) begin
      prod_q     <= DivisorW'({16'd0, vel} * {16'd0, kconst});
      need_div_q <= need_div;
    end
    if (fin_fire) begin
      // invalid channels report zeros in the count, velocity and rpm fields
      m_user_q <= valid;
      m_data_q <= {5'd0, redisc,
                   valid ? rpm_n : {RpmW{1'b0}},
                   valid ? vel_n : 16'd0,
                   valid ? delta_n : 32'd0,
                   valid ? rel_n : 32'd0,
                   ch_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  a_done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside the divide step");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised without a finishing step");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q[97:3] == '0))
    else $error("invalid channel reports nonzero fields");

endmodule

`default_nettype wire
